[rtl/core/fct_pkg.sv]
// Shared types, codes and fixed-point constants for the frustum culling test.
`timescale 1ns / 1ps

package fct_pkg;

    localparam int NUM_PLANES      = 6;
    localparam int NEAR_PLANE      = 5;
    localparam int PLANE_COUNT_DEF = 6;
    localparam int PLANE_W         = 64;
    localparam int ADDR_W          = 6;
    localparam int INDEX_W         = 3;

    localparam int FRAC      = 14;
    localparam int PROD_W    = 32;
    localparam int EXT_PW    = 31;
    localparam int DIST_W    = 35;
    localparam int EXT_W     = 33;
    localparam int SUM_W     = 36;
    localparam int ADD_W     = 17;
    localparam int NUM_W     = 37;
    localparam int QUO_IN_W  = 21;
    localparam int RECIP_W   = 23;
    localparam int RECIP_SH  = 24;
    localparam int MUL_W     = QUO_IN_W + RECIP_W;
    localparam int QUO_W     = MUL_W - RECIP_SH;
    localparam int OUT_DIST_W = 18;

    localparam logic [RECIP_W-1:0]    RECIP_THIRD = 23'd5592406;
    localparam logic [OUT_DIST_W-1:0] DIST_MAX    = 18'd262143;

    localparam logic [1:0] SHAPE_POINT  = 2'd0;
    localparam logic [1:0] SHAPE_SPHERE = 2'd1;
    localparam logic [1:0] SHAPE_BOX    = 2'd2;

    localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
    localparam logic [1:0] VERDICT_CROSS   = 2'd1;
    localparam logic [1:0] VERDICT_INSIDE  = 2'd2;

    typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] t_plane_bank;

    typedef struct packed {
        logic outside;
        logic fully_in;
    } t_lane_flags;

endpackage

[rtl/core/fct_regs.sv]
// Plane coefficient registers behind the APB configuration port.
`timescale 1ns / 1ps

module fct_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fct_pkg::ADDR_W-1:0]        paddr,
    input  logic [fct_pkg::PLANE_W-1:0]       pwdata,
    output logic [fct_pkg::PLANE_W-1:0]       prdata,
    output logic                              pready,
    output fct_pkg::t_plane_bank              o_planes
);

    fct_pkg::t_plane_bank              r_planes;
    logic [fct_pkg::INDEX_W-1:0]       w_index;
    logic                              w_hit;
    logic                              w_write;

    assign w_index = paddr[fct_pkg::ADDR_W-1:fct_pkg::ADDR_W-fct_pkg::INDEX_W];
    assign w_hit   = (w_index < fct_pkg::INDEX_W'(fct_pkg::NUM_PLANES));
    assign w_write = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (w_write && w_hit) begin
            r_planes[w_index] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = r_planes[w_index];
        end
    end

    assign o_planes = r_planes;

endmodule

[rtl/core/fct_lane.sv]
// One plane lane: registered products, then signed distance and extent, then the side flags.
`timescale 1ns / 1ps

module fct_lane (
    input  logic                                 i_clk,
    input  logic [fct_pkg::PLANE_W-1:0]          i_plane,
    input  logic [1:0]                           i_func,
    input  logic signed [15:0]                   i_cx,
    input  logic signed [15:0]                   i_cy,
    input  logic signed [15:0]                   i_cz,
    input  logic [14:0]                          i_hx,
    input  logic [14:0]                          i_hy,
    input  logic [14:0]                          i_hz,
    output logic signed [fct_pkg::DIST_W-1:0]    o_dist,
    output fct_pkg::t_lane_flags                 o_flags
);

    logic signed [15:0] w_a;
    logic signed [15:0] w_b;
    logic signed [15:0] w_c;
    logic signed [15:0] w_d;
    logic [15:0]        w_abs_a;
    logic [15:0]        w_abs_b;
    logic [15:0]        w_abs_c;

    logic signed [fct_pkg::PROD_W-1:0] r1_px;
    logic signed [fct_pkg::PROD_W-1:0] r1_py;
    logic signed [fct_pkg::PROD_W-1:0] r1_pz;
    logic [fct_pkg::EXT_PW-1:0]        r1_ex;
    logic [fct_pkg::EXT_PW-1:0]        r1_ey;
    logic [fct_pkg::EXT_PW-1:0]        r1_ez;
    logic [1:0]                        r1_func;
    logic [14:0]                       r1_hx;

    logic signed [fct_pkg::DIST_W-1:0] n_dist;
    logic [fct_pkg::EXT_W-1:0]         n_ext;
    logic signed [fct_pkg::DIST_W-1:0] r2_dist;
    logic [fct_pkg::EXT_W-1:0]         r2_ext;

    logic signed [fct_pkg::SUM_W-1:0]  w_ext_s;
    logic signed [fct_pkg::SUM_W-1:0]  w_hi;
    logic signed [fct_pkg::SUM_W-1:0]  w_lo;
    fct_pkg::t_lane_flags              n_flags;
    fct_pkg::t_lane_flags              r3_flags;

    assign w_a = $signed(i_plane[15:0]);
    assign w_b = $signed(i_plane[31:16]);
    assign w_c = $signed(i_plane[47:32]);
    assign w_d = $signed(i_plane[63:48]);

    assign w_abs_a = w_a[15] ? (~i_plane[15:0] + 16'd1) : i_plane[15:0];
    assign w_abs_b = w_b[15] ? (~i_plane[31:16] + 16'd1) : i_plane[31:16];
    assign w_abs_c = w_c[15] ? (~i_plane[47:32] + 16'd1) : i_plane[47:32];

    always_ff @(posedge i_clk) begin
        r1_px   <= w_a * i_cx;
        r1_py   <= w_b * i_cy;
        r1_pz   <= w_c * i_cz;
        r1_ex   <= w_abs_a * i_hx;
        r1_ey   <= w_abs_b * i_hy;
        r1_ez   <= w_abs_c * i_hz;
        r1_func <= i_func;
        r1_hx   <= i_hx;
    end

    always_comb begin
        n_dist = fct_pkg::DIST_W'(r1_px) + fct_pkg::DIST_W'(r1_py)
               + fct_pkg::DIST_W'(r1_pz)
               + (fct_pkg::DIST_W'(w_d) <<< fct_pkg::FRAC);
        case (r1_func)
            fct_pkg::SHAPE_POINT: begin
                n_ext = '0;
            end
            fct_pkg::SHAPE_SPHERE: begin
                n_ext = fct_pkg::EXT_W'(r1_hx) << fct_pkg::FRAC;
            end
            default: begin
                n_ext = fct_pkg::EXT_W'(r1_ex) + fct_pkg::EXT_W'(r1_ey)
                      + fct_pkg::EXT_W'(r1_ez);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r2_dist <= n_dist;
        r2_ext  <= n_ext;
    end

    always_comb begin
        w_ext_s          = fct_pkg::SUM_W'($signed({1'b0, r2_ext}));
        w_hi             = fct_pkg::SUM_W'(r2_dist) + w_ext_s;
        w_lo             = fct_pkg::SUM_W'(r2_dist) - w_ext_s;
        n_flags.outside  = (w_hi <= 0);
        n_flags.fully_in = (w_lo > 0);
    end

    always_ff @(posedge i_clk) begin
        r3_flags <= n_flags;
    end

    assign o_dist  = r2_dist;
    assign o_flags = r3_flags;

endmodule

[rtl/core/fct_dist.sv]
// Near-plane distance: adds the shape term, divides by three and saturates.
`timescale 1ns / 1ps

module fct_dist (
    input  logic                                 i_clk,
    input  logic [1:0]                           i_func,
    input  logic [14:0]                          i_hx,
    input  logic [14:0]                          i_hy,
    input  logic [14:0]                          i_hz,
    input  logic signed [fct_pkg::DIST_W-1:0]    i_dn,
    output logic [fct_pkg::OUT_DIST_W-1:0]       o_dist
);

    logic [fct_pkg::ADD_W-1:0]         n_add;
    logic [fct_pkg::ADD_W-1:0]         r1_add;
    logic [fct_pkg::ADD_W-1:0]         r2_add;
    logic signed [fct_pkg::NUM_W-1:0]  n_num;
    logic signed [fct_pkg::NUM_W-1:0]  r3_num;
    logic                              r4_pos;
    logic [fct_pkg::MUL_W-1:0]         r4_prod;
    logic [fct_pkg::QUO_W-1:0]         w_quo;

    always_comb begin
        case (i_func)
            fct_pkg::SHAPE_POINT: begin
                n_add = '0;
            end
            fct_pkg::SHAPE_SPHERE: begin
                n_add = fct_pkg::ADD_W'(i_hx) + (fct_pkg::ADD_W'(i_hx) << 1);
            end
            default: begin
                n_add = fct_pkg::ADD_W'(i_hx) + fct_pkg::ADD_W'(i_hy)
                      + fct_pkg::ADD_W'(i_hz);
            end
        endcase
    end

    assign n_num = (fct_pkg::NUM_W'(i_dn) <<< 1) + fct_pkg::NUM_W'(i_dn)
                 + fct_pkg::NUM_W'($signed({1'b0, r2_add, {fct_pkg::FRAC{1'b0}}}));

    always_ff @(posedge i_clk) begin
        r1_add  <= n_add;
        r2_add  <= r1_add;
        r3_num  <= n_num;
        r4_pos  <= (r3_num > 0);
        r4_prod <= r3_num[fct_pkg::FRAC+fct_pkg::QUO_IN_W-1:fct_pkg::FRAC]
                 * fct_pkg::RECIP_THIRD;
    end

    assign w_quo = r4_prod[fct_pkg::MUL_W-1:fct_pkg::RECIP_SH];

    always_comb begin
        if (!r4_pos) begin
            o_dist = '0;
        end else if (w_quo > fct_pkg::QUO_W'(fct_pkg::DIST_MAX)) begin
            o_dist = fct_pkg::DIST_MAX;
        end else begin
            o_dist = w_quo[fct_pkg::OUT_DIST_W-1:0];
        end
    end

endmodule

[rtl/core/frustum_cull_test.sv]
// Top level of the frustum culling test: registers, plane lanes, verdict and distance.
//
// Channel   Direction  Handshake                 Word
// input     in         start high, busy low      i_func, i_center_*, i_half_*
// result    out        o_strobe for one cycle    o_verdict, o_near_distance
// config    in/out     APB, written at access    pwdata to plane at paddr/8
//
// A new word may be started in every cycle; busy stays low.
// Each result appears in start order, after the plane multipliers, the distance adder tree,
// the side compare and the reciprocal multiply for the division by three.
// Reset clears the plane registers and the valid pipeline; the receiver cannot stall.
`timescale 1ns / 1ps

module frustum_cull_test #(
    parameter int PLANE_COUNT = fct_pkg::PLANE_COUNT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_func,
    input  logic signed [15:0]                   i_center_x,
    input  logic signed [15:0]                   i_center_y,
    input  logic signed [15:0]                   i_center_z,
    input  logic [14:0]                          i_half_x,
    input  logic [14:0]                          i_half_y,
    input  logic [14:0]                          i_half_z,
    output logic                                 o_strobe,
    output logic [1:0]                           o_verdict,
    output logic [fct_pkg::OUT_DIST_W-1:0]       o_near_distance,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fct_pkg::ADDR_W-1:0]           paddr,
    input  logic [fct_pkg::PLANE_W-1:0]          pwdata,
    output logic [fct_pkg::PLANE_W-1:0]          prdata,
    output logic                                 pready
);

    localparam int USED = (PLANE_COUNT < fct_pkg::NUM_PLANES) ? PLANE_COUNT
                                                             : fct_pkg::NUM_PLANES;

    fct_pkg::t_plane_bank               w_planes;
    fct_pkg::t_lane_flags               w_flags [USED];
    logic [USED-1:0]                    w_out;
    logic [USED-1:0]                    w_in;
    logic signed [fct_pkg::DIST_W-1:0]  w_near_dist;
    logic [fct_pkg::OUT_DIST_W-1:0]     w_dist;
    logic                               w_accept;
    logic [3:0]                         r_vld;
    logic [1:0]                         n_verdict;
    logic [1:0]                         r4_verdict;
    logic                               r_strobe;
    logic [1:0]                         r_verdict;
    logic [fct_pkg::OUT_DIST_W-1:0]     r_dist;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    fct_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_planes (w_planes)
    );

    for (genvar p = 0; p < USED; p++) begin : g_lane
        fct_lane u_lane (
            .i_clk   (i_clk),
            .i_plane (w_planes[p]),
            .i_func  (i_func),
            .i_cx    (i_center_x),
            .i_cy    (i_center_y),
            .i_cz    (i_center_z),
            .i_hx    (i_half_x),
            .i_hy    (i_half_y),
            .i_hz    (i_half_z),
            .o_dist  (),
            .o_flags (w_flags[p])
        );
        assign w_out[p] = w_flags[p].outside;
        assign w_in[p]  = w_flags[p].fully_in;
    end

    fct_lane u_near_lane (
        .i_clk   (i_clk),
        .i_plane (w_planes[fct_pkg::NEAR_PLANE]),
        .i_func  (i_func),
        .i_cx    (i_center_x),
        .i_cy    (i_center_y),
        .i_cz    (i_center_z),
        .i_hx    (i_half_x),
        .i_hy    (i_half_y),
        .i_hz    (i_half_z),
        .o_dist  (w_near_dist),
        .o_flags ()
    );

    fct_dist u_dist (
        .i_clk  (i_clk),
        .i_func (i_func),
        .i_hx   (i_half_x),
        .i_hy   (i_half_y),
        .i_hz   (i_half_z),
        .i_dn   (w_near_dist),
        .o_dist (w_dist)
    );

    always_comb begin
        if (|w_out) begin
            n_verdict = fct_pkg::VERDICT_OUTSIDE;
        end else if (&w_in) begin
            n_verdict = fct_pkg::VERDICT_INSIDE;
        end else begin
            n_verdict = fct_pkg::VERDICT_CROSS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[2:0], w_accept};
            r_strobe <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r4_verdict <= n_verdict;
        r_verdict  <= r4_verdict;
        if (r4_verdict == fct_pkg::VERDICT_OUTSIDE) begin
            r_dist <= '0;
        end else begin
            r_dist <= w_dist;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_verdict       = r_verdict;
    assign o_near_distance = r_dist;

    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, 5))
        else $error("Result word without a started word five cycles earlier.");

    a_outside_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_verdict == fct_pkg::VERDICT_OUTSIDE) |-> o_near_distance == '0)
        else $error("Outside verdict carries a nonzero near distance.");

    a_point_not_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(w_accept && i_func == fct_pkg::SHAPE_POINT, 5))
        |-> o_verdict != fct_pkg::VERDICT_CROSS)
        else $error("Point word classified as intersecting.");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_verdict == fct_pkg::VERDICT_OUTSIDE
                   || o_verdict == fct_pkg::VERDICT_CROSS
                   || o_verdict == fct_pkg::VERDICT_INSIDE))
        else $error("Result word carries an unused verdict code.");

endmodule
